// ===== design/lfcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lfcr_pkg: shared definitions of the LRU/FIFO cache replacement unit
// Sizes, register indexes, policy codes, costs, the per-cell control word
// and the key folding function.
// ---------------------------------------------------------------------------
package lfcr_pkg;

   // Cache geometry and key format.
   localparam int CAPACITY  = 16;
   localparam int KEY_BYTES = 8;
   localparam int KEY_W     = 64;
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int COST_W    = 32;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam int SIZE_W     = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CACHE_SIZE = 2'd0,
      CSR_POLICY     = 2'd1
   } csr_index_type;

   typedef enum logic {
      POLICY_LRU  = 1'b0,
      POLICY_FIFO = 1'b1
   } policy_type;

   // Access costs.
   localparam logic [COST_W-1:0] HIT_COST  = COST_W'(1);
   localparam logic [COST_W-1:0] MISS_COST = COST_W'(5);

   // ASCII letter range folded to lower case.
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // Control word handed to one cell of the entry chain.
   typedef struct packed {
      logic shift;  // take the key of the younger neighbor
      logic load;   // take the request key
   } cell_ctrl_type;

   // Fold upper case to lower case; the key ends at its first zero byte
   // and bytes beyond KEY_BYTES count as zero.
   function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] raw);
      logic [KEY_W-1:0] folded;
      logic             alive;
      logic [7:0]       c;
      folded = '0;
      alive  = 1'b1;
      for (int i = 0; i < 8; i++) begin
         c = raw[8*i +: 8];
         if (c == 8'h00 || i >= KEY_BYTES) begin
            alive = 1'b0;
         end
         if (alive) begin
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
               c = c + CASE_OFFSET;
            end
            folded[8*i +: 8] = c;
         end
      end
      return folded;
   endfunction

endpackage
`default_nettype wire

// ===== design/lfcr_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lfcr_req_if: request channel
// Valid/ready channel carrying one request word: key and last flag.
// ---------------------------------------------------------------------------
interface lfcr_req_if;
   logic                      valid;
   logic                      ready;
   logic [lfcr_pkg::KEY_W-1:0] key;
   logic                      last_request;

   modport source (output valid, output key, output last_request, input ready);
   modport sink   (input valid, input key, input last_request, output ready);
endinterface
`default_nettype wire

// ===== design/lfcr_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lfcr_rsp_if: response channel
// Valid/ready channel carrying one result word: hit, cost and end flag.
// ---------------------------------------------------------------------------
interface lfcr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic [lfcr_pkg::COST_W-1:0] total_time;
   logic                        sequence_end;

   modport source (output valid, output hit, output total_time, output sequence_end,
                   input ready);
   modport sink   (input valid, input hit, input total_time, input sequence_end,
                   output ready);
endinterface
`default_nettype wire

// ===== design/lru_fifo_cache_replacement_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lru_fifo_cache_replacement_unit: LRU/FIFO cache replacement simulator
// Looks request keys up in a fully associative cache and keeps the cost.
// ---------------------------------------------------------------------------
// Usage:
//   req_if carries one request word per handshake: a key of up to eight
//   ASCII bytes and a last flag. rsp_if returns one word per request: the
//   hit flag, the saturating running cost and the echoed last flag.
//   Each request is resolved in the cycle it is accepted: all entry cells
//   compare in parallel and the age-ordered chain shifts by one step. The
//   result appears in the output register in the cycle after acceptance; a new
//   request is taken every cycle while results are taken (throughput one word per cycle).
//   If the receiver stalls, the result stays in the output register and a
//   new request is accepted only at the edge where that result is taken.
//   A request marked last clears the cache and the cost after its result.
//   Reset (synchronous) empties the cache, clears the cost and the output
//   valid flag, and sets cache_size to 3 and the policy to LRU; no clearing
//   pass is needed. Write csr_* only while the block is idle.
// ---------------------------------------------------------------------------
module lru_fifo_cache_replacement_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   lfcr_req_if.sink                            req_if,
   lfcr_rsp_if.source                          rsp_if,
   input  wire logic                           csr_we,
   input  wire logic [lfcr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lfcr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lfcr_pkg::*;

   localparam int CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

   // Configuration registers.
   logic [SIZE_W-1:0] cache_size_ff;
   policy_type        policy_ff;

   // Cache bookkeeping and cost.
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [COST_W-1:0] cost_ff, cost_in;

   // Output register.
   logic              rsp_valid_ff;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [COST_W-1:0] rsp_total_ff;
   logic              rsp_end_ff;

   logic              accept;
   logic [KEY_W-1:0]  fkey;
   logic [CNT_W-1:0]  size_eff;
   logic              size_zero;
   logic              any_match;
   logic              do_hit_shift, do_evict, do_fill;
   logic [COST_W:0]   cost_sum;

   logic [KEY_W-1:0]    cell_key  [CAPACITY];
   logic [CAPACITY-1:0] cell_match;
   logic [CAPACITY:0]   seen;
   cell_ctrl_type       cell_ctrl [CAPACITY];

   // Handshake: the output register frees up when its word is taken.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign fkey         = fold_key(req_if.key);

   // Cache size above the capacity acts as the capacity.
   always_comb begin
      if (CMP_W'(cache_size_ff) > CMP_W'(CAPACITY)) begin
         size_eff = CNT_W'(CAPACITY);
      end else begin
         size_eff = CNT_W'(cache_size_ff);
      end
   end
   assign size_zero = (size_eff == '0);

   // Entry chain, oldest entry in cell 0.
   assign seen[0] = 1'b0;
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [KEY_W-1:0] next_key;
      if (k == CAPACITY - 1) begin : g_tail
         assign next_key = fkey;
      end else begin : g_body
         assign next_key = cell_key[k+1];
      end

      // Shift towards the old end from the hit position, or all on eviction;
      // the newest occupied cell, or the first free one, takes the request.
      always_comb begin
         cell_ctrl[k].shift = accept && (CNT_W'(k + 1) < count_ff)
                              && ((do_hit_shift && seen[k+1]) || do_evict);
         cell_ctrl[k].load  = accept
                              && (((do_hit_shift || do_evict) && CNT_W'(k + 1) == count_ff)
                                  || (do_fill && CNT_W'(k) == count_ff));
      end

      lfcr_cell u_cell (
         .clock    (clock),
         .valid    (CNT_W'(k) < count_ff),
         .req_key  (fkey),
         .next_key (next_key),
         .ctrl     (cell_ctrl[k]),
         .seen_in  (seen[k]),
         .key      (cell_key[k]),
         .match    (cell_match[k]),
         .seen_out (seen[k+1])
      );
   end

   // Hit or miss, and what the cache does about it.
   assign any_match    = seen[CAPACITY];
   assign rsp_hit_in   = !size_zero && any_match;
   assign do_hit_shift = rsp_hit_in && (policy_ff == POLICY_LRU);
   assign do_fill      = !size_zero && !any_match && (count_ff < size_eff);
   assign do_evict     = !size_zero && !any_match && (count_ff >= size_eff)
                         && (count_ff != '0);

   // Saturating running cost.
   assign cost_sum = {1'b0, cost_ff} + {1'b0, (rsp_hit_in ? HIT_COST : MISS_COST)};
   always_comb begin
      cost_in = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];
   end

   // Entry count: grows on fill, clears at the end of a sequence.
   always_comb begin
      count_in = count_ff;
      if (do_fill) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (req_if.last_request) begin
         count_in = '0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cost_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
            cost_ff  <= req_if.last_request ? '0 : cost_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cache_size_ff <= SIZE_W'(3);
         policy_ff     <= POLICY_LRU;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CACHE_SIZE: cache_size_ff <= csr_wdata[SIZE_W-1:0];
            CSR_POLICY:     policy_ff     <= policy_type'(csr_wdata[0]);
            default:        ;
         endcase
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_hit_ff   <= rsp_hit_in;
         rsp_total_ff <= cost_in;
         rsp_end_ff   <= req_if.last_request;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.hit          = rsp_hit_ff;
   assign rsp_if.total_time   = rsp_total_ff;
   assign rsp_if.sequence_end = rsp_end_ff;

`ifndef SYNTHESIS
   // The cache never holds more entries than it has cells.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   // Keys in the cache are unique, so at most one cell matches.
   a_single_match : assert property (@(posedge clock) disable iff (reset)
      $onehot0(cell_match))
      else $error("more than one cell matches the request");

   // A request marked last leaves an empty cache and zero cost.
   a_sequence_clear : assert property (@(posedge clock) disable iff (reset)
      accept && req_if.last_request |=> count_ff == '0 && cost_ff == '0)
      else $error("state not cleared after the last request");

   // Every delivered word carries at least the cost of one access.
   a_cost_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_total_ff != '0)
      else $error("result word with zero cost");
`endif

endmodule
`default_nettype wire

// ===== design/lfcr_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lfcr_cell: one entry of the age-ordered cache chain
// Holds one key, compares it with the request and shifts or loads on command.
// ---------------------------------------------------------------------------
module lfcr_cell (
   input  wire logic                        clock,
   input  wire logic                        valid,
   input  wire logic [lfcr_pkg::KEY_W-1:0]  req_key,
   input  wire logic [lfcr_pkg::KEY_W-1:0]  next_key,
   input  wire lfcr_pkg::cell_ctrl_type     ctrl,
   input  wire logic                        seen_in,
   output logic      [lfcr_pkg::KEY_W-1:0]  key,
   output logic                             match,
   output logic                             seen_out
);
   import lfcr_pkg::*;

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;

   // Compare only an occupied entry; pass on whether this or any older one matched.
   assign match    = valid && (key_ff == req_key);
   assign seen_out = seen_in || match;
   assign key      = key_ff;

   // Load the request key, or take over the younger neighbor's key.
   always_comb begin
      key_in = key_ff;
      if (ctrl.load) begin
         key_in = req_key;
      end else if (ctrl.shift) begin
         key_in = next_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule
`default_nettype wire
